// ===== rtl/htfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and arithmetic helpers for the sensor frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

   // Byte slots of the six-byte measurement frame
   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } frame_pos_type;

   localparam logic [7:0]  CRC_INIT      = 8'hFF;
   localparam logic [7:0]  CRC_POLY_RST  = 8'h31;

   // Scaling: 175*raw and 100*raw over full scale 65535, offset 45*65535
   localparam int          TEMP_PROD_W   = 24;
   localparam int          HUM_PROD_W    = 23;
   localparam logic [23:0] TEMP_SCALE    = 24'd175;
   localparam logic [22:0] HUM_SCALE     = 23'd100;
   localparam logic [23:0] TEMP_OFFSET   = 24'd2949075;
   localparam logic [16:0] FULL_SCALE    = 17'd65535;

   // One CRC-8 byte step, MSB first, polynomial without its top bit
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ poly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   // Divide a value below 2^24 by 65535: x = q0*65535 + (q0 + lo),
   // and q0 + lo stays below twice the divisor, so one correction step.
   function automatic logic [7:0] div_full_scale(input logic [23:0] x);
      logic [7:0]  q0;
      logic [16:0] r;
      q0 = x[23:16];
      r  = {1'b0, x[15:0]} + {9'd0, q0};
      return q0 + ((r >= FULL_SCALE) ? 8'd1 : 8'd0);
   endfunction

endpackage : htfd_pkg
`default_nettype wire

// ===== rtl/humidity_temperature_frame_decode_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decode_core
// Checks and scales the six-byte temperature/humidity sensor frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one frame byte per beat (valid/ready). req_frame_start marks byte
//           0 of a frame and drops any partial frame. Without it, the byte
//           position just advances and wraps after byte 5.
//   rsp_* : one result beat per frame, produced by byte 5: temperature in
//           whole degrees (signed), humidity in percent and a CRC error flag.
//           On a CRC error the last good values are repeated.
//   csr_* : CRC-8 polynomial register (reset 0x31), written when idle; the
//           user must keep to this, the block does not enforce it.
// Throughput: one byte per cycle when not stalled. The CRC byte step is
//   combinational; the constant-divisor scaling is split over two
//   register stages: byte 5 loads the product, then the quotient is stored.
// Stall: when rsp_ready is low the result register holds; the product
//   stage still takes one more frame-end beat, after which req_ready drops
//   until the result is taken. Non-final bytes go through the same stall.
// Reset: synchronous; position 0, CRC 0xFF, polynomial 0x31, last good
//   values 0 degrees / 0 percent, both pipeline stages empty.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decode_core
   import htfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   // byte input
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_frame_byte,
   input  wire logic              req_frame_start,
   // result output
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [8:0]      rsp_temperature_deg,
   output logic [6:0]             rsp_humidity_pct,
   output logic                   rsp_crc_error
);

   // --- configuration register ---
   logic [7:0]          crc_poly_ff;

   // --- frame parse state ---
   frame_pos_type       pos_ff, pos_in, pos_cur;
   logic [7:0]          crc_ff, crc_in, crc_base;
   logic                temp_ok_ff, temp_ok_in;
   logic [15:0]         temp_raw_ff, temp_raw_in;
   logic [15:0]         hum_raw_ff, hum_raw_in;

   // --- product stage ---
   logic                s1_valid_ff;
   logic                s1_ok_ff;
   logic [TEMP_PROD_W-1:0] s1_temp_prod_ff;
   logic [HUM_PROD_W-1:0]  s1_hum_prod_ff;

   // --- result stage ---
   logic                rsp_valid_ff;
   logic signed [8:0]   last_temp_ff, last_temp_in;
   logic [6:0]          last_hum_ff, last_hum_in;
   logic                crc_err_ff;

   logic                accept;
   logic                frame_end;
   logic                rsp_load;
   logic                s1_free;
   logic                frame_ok;

   logic [TEMP_PROD_W-1:0] temp_dist;
   logic                   temp_neg;
   logic [7:0]             temp_mag;
   logic [7:0]             hum_q;

   // handshake: result register drains or is empty -> product stage moves
   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free   = !s1_valid_ff || rsp_load;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // byte slot of the incoming beat
   assign pos_cur   = req_frame_start ? POS_TEMP_HI : pos_ff;
   assign frame_end = accept && (pos_cur == POS_HUM_CRC);

   // CRC restarts at the first byte of each word
   assign crc_base  = ((pos_cur == POS_TEMP_HI) || (pos_cur == POS_HUM_HI)) ?
                      CRC_INIT : crc_ff;
   assign frame_ok  = temp_ok_ff && (crc_ff == req_frame_byte);

   always_comb begin
      crc_in      = crc_ff;
      temp_ok_in  = temp_ok_ff;
      temp_raw_in = temp_raw_ff;
      hum_raw_in  = hum_raw_ff;
      pos_in      = pos_ff;
      if (accept) begin
         case (pos_cur)
            POS_TEMP_HI: begin
               temp_raw_in = {req_frame_byte, 8'd0};
               crc_in      = crc8_byte(crc_base, req_frame_byte, crc_poly_ff);
               pos_in      = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
               temp_raw_in = {temp_raw_ff[15:8], req_frame_byte};
               crc_in      = crc8_byte(crc_base, req_frame_byte, crc_poly_ff);
               pos_in      = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               temp_ok_in  = (crc_ff == req_frame_byte);
               pos_in      = POS_HUM_HI;
            end
            POS_HUM_HI: begin
               hum_raw_in  = {req_frame_byte, 8'd0};
               crc_in      = crc8_byte(crc_base, req_frame_byte, crc_poly_ff);
               pos_in      = POS_HUM_LO;
            end
            POS_HUM_LO: begin
               hum_raw_in  = {hum_raw_ff[15:8], req_frame_byte};
               crc_in      = crc8_byte(crc_base, req_frame_byte, crc_poly_ff);
               pos_in      = POS_HUM_CRC;
            end
            POS_HUM_CRC: begin
               pos_in      = POS_TEMP_HI;
            end
            default: begin
               pos_in      = POS_TEMP_HI;
            end
         endcase
      end
   end

   // quotient stage: |175*raw - 45*65535| / 65535, sign applied after
   assign temp_neg  = (s1_temp_prod_ff < TEMP_OFFSET);
   assign temp_dist = temp_neg ? (TEMP_OFFSET - s1_temp_prod_ff)
                               : (s1_temp_prod_ff - TEMP_OFFSET);
   assign temp_mag  = div_full_scale(temp_dist);
   assign hum_q     = div_full_scale({1'b0, s1_hum_prod_ff});

   always_comb begin
      last_temp_in = last_temp_ff;
      last_hum_in  = last_hum_ff;
      if (rsp_load && s1_ok_ff) begin
         last_temp_in = temp_neg ? -$signed({1'b0, temp_mag})
                                 :  $signed({1'b0, temp_mag});
         last_hum_in  = hum_q[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff  <= CRC_POLY_RST;
         pos_ff       <= POS_TEMP_HI;
         crc_ff       <= CRC_INIT;
         temp_ok_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_temp_ff <= '0;
         last_hum_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            crc_poly_ff <= csr_wr_data;
         end
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_ok_ff   <= temp_ok_in;
         last_temp_ff <= last_temp_in;
         last_hum_ff  <= last_hum_in;
         if (s1_free) begin
            s1_valid_ff <= frame_end;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      temp_raw_ff <= temp_raw_in;
      hum_raw_ff  <= hum_raw_in;
      if (frame_end) begin
         s1_ok_ff        <= frame_ok;
         s1_temp_prod_ff <= {8'd0, temp_raw_ff} * TEMP_SCALE;
         s1_hum_prod_ff  <= {7'd0, hum_raw_ff} * HUM_SCALE;
      end
      if (rsp_load) begin
         crc_err_ff <= !s1_ok_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temperature_deg = last_temp_ff;
   assign rsp_humidity_pct    = last_hum_ff;
   assign rsp_crc_error       = crc_err_ff;

endmodule : humidity_temperature_frame_decode_core
`default_nettype wire

// ===== sim/humidity_temperature_frame_decode_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decode_checker
// Watches the byte, result and CSR ports of the frame decoder. Keeps its own
// copy of the frame state, predicts one reading per frame and compares each
// result beat against the oldest pending reading.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decode_checker
   import htfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [7:0]        req_frame_byte,
   input  wire logic              req_frame_start,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic signed [8:0] rsp_temperature_deg,
   input  wire logic [6:0]        rsp_humidity_pct,
   input  wire logic              rsp_crc_error,
   output int                     mismatch_count,
   output int                     pending_beats
);

   localparam int unsigned DEG_OFFSET = 45 * 65535;
   localparam int unsigned FULL_SPAN  = 65535;

   typedef struct packed {
      logic signed [8:0] temperature;
      logic [6:0]        humidity;
      logic              crc_error;
   } sensor_reading_type;

   sensor_reading_type readings_due[$];
   int                failures = 0;

   // shadow of the decoder state
   logic [7:0]        crc_poly;
   frame_pos_type     byte_slot;
   logic [7:0]        word_crc;
   logic              temp_ok;
   logic [15:0]       temp_word;
   logic [15:0]       hum_word;
   logic signed [8:0] good_temp;
   logic [6:0]        good_hum;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      repeat (8) begin
         acc = acc[7] ? ({acc[6:0], 1'b0} ^ crc_poly) : {acc[6:0], 1'b0};
      end
      return acc;
   endfunction

   // exact integer scaling; temperature truncates toward zero
   function automatic sensor_reading_type scale_reading(input logic [15:0] t_raw,
                                                        input logic [15:0] h_raw);
      sensor_reading_type r;
      int unsigned     scaled;
      int              deg;
      scaled = 175 * t_raw;
      if (scaled >= DEG_OFFSET) begin
         deg = int'((scaled - DEG_OFFSET) / FULL_SPAN);
      end else begin
         deg = -int'((DEG_OFFSET - scaled) / FULL_SPAN);
      end
      r.temperature = 9'(deg);
      r.humidity    = 7'((100 * h_raw) / FULL_SPAN);
      r.crc_error   = 1'b0;
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] b, input logic s);
      frame_pos_type      pos;
      sensor_reading_type r;
      pos = s ? POS_TEMP_HI : byte_slot;
      if (pos == POS_TEMP_HI || pos == POS_HUM_HI) begin
         word_crc = CRC_INIT;
      end
      case (pos)
         POS_TEMP_HI: begin
            temp_word = {b, 8'h00};
            word_crc  = crc_step(word_crc, b);
         end
         POS_TEMP_LO: begin
            temp_word[7:0] = b;
            word_crc       = crc_step(word_crc, b);
         end
         POS_TEMP_CRC: temp_ok = (word_crc == b);
         POS_HUM_HI: begin
            hum_word = {b, 8'h00};
            word_crc = crc_step(word_crc, b);
         end
         POS_HUM_LO: begin
            hum_word[7:0] = b;
            word_crc      = crc_step(word_crc, b);
         end
         default: ;
      endcase
      if (pos != POS_HUM_CRC) begin
         byte_slot = frame_pos_type'(pos + 3'd1);
      end else begin
         byte_slot = POS_TEMP_HI;
         r.crc_error = !(temp_ok && word_crc == b);
         if (!r.crc_error) begin
            r         = scale_reading(temp_word, hum_word);
            good_temp = r.temperature;
            good_hum  = r.humidity;
         end
         r.temperature = good_temp;
         r.humidity    = good_hum;
         readings_due.push_back(r);
      end
   endtask

   task automatic check_reading();
      sensor_reading_type want;
      if (readings_due.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("unexpected result beat: temp %0d hum %0d err %0b",
                     rsp_temperature_deg, rsp_humidity_pct, rsp_crc_error);
         end
      end else begin
         want = readings_due.pop_front();
         if (rsp_temperature_deg !== want.temperature || rsp_humidity_pct !== want.humidity
             || rsp_crc_error !== want.crc_error) begin
            failures++;
            if (failures <= 10) begin
               $display({"result mismatch: got temp %0d hum %0d err %0b,",
                         " want temp %0d hum %0d err %0b"},
                        rsp_temperature_deg, rsp_humidity_pct, rsp_crc_error,
                        $signed(want.temperature), want.humidity, want.crc_error);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         crc_poly   = CRC_POLY_RST;
         byte_slot  = POS_TEMP_HI;
         word_crc   = CRC_INIT;
         temp_ok    = 1'b0;
         temp_word  = '0;
         hum_word   = '0;
         good_temp  = '0;
         good_hum   = '0;
         readings_due.delete();
      end else begin
         if (csr_wr_en) begin
            crc_poly = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            check_reading();
         end
         if (req_valid && req_ready) begin
            absorb_byte(req_frame_byte, req_frame_start);
         end
      end
      pending_beats  <= readings_due.size();
      mismatch_count <= failures;
   end

endmodule : humidity_temperature_frame_decode_checker
`default_nettype wire

// ===== sim/humidity_temperature_frame_decode_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decode_core_tb
// Drives six-byte sensor frames into the decoder under several CRC
// polynomials: a short directed opening, then mostly well-formed frames with
// random words and occasional bad CRCs, mixed with stray bytes and restarts.
// Both ports idle in random bursts. The checker beside the block does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decode_core_tb;
   import htfd_pkg::*;

   localparam int TOTAL_BYTES  = 1350;
   localparam int PHASES       = 5;
   localparam int QUIET_BYTES  = 150;     // final stretch runs without idling
   localparam int DRAIN_CYCLES = 8;       // pipeline is two deep; leave margin
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [7:0]        csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_frame_byte;
   logic              req_frame_start;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [8:0] rsp_temperature_deg;
   logic [6:0]        rsp_humidity_pct;
   logic              rsp_crc_error;

   int                mismatch_count;
   int                pending_beats;

   // stimulus-side bookkeeping
   int                sent_bytes  = 0;
   int                byte_slot   = 0;    // where the next byte lands, 0..5
   int                gap_odds    = 3;    // 0 disables sender gaps
   int                cycle_count = 0;
   logic              quiet_tail  = 1'b0;
   logic [7:0]        crc_poly_now = CRC_POLY_RST;

   humidity_temperature_frame_decode_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_byte      (req_frame_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temperature_deg (rsp_temperature_deg),
      .rsp_humidity_pct    (rsp_humidity_pct),
      .rsp_crc_error       (rsp_crc_error)
   );

   humidity_temperature_frame_decode_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_byte      (req_frame_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temperature_deg (rsp_temperature_deg),
      .rsp_humidity_pct    (rsp_humidity_pct),
      .rsp_crc_error       (rsp_crc_error),
      .mismatch_count      (mismatch_count),
      .pending_beats       (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side back-pressure: stall bursts separated by short or long ready
   // stretches. Stalls stop once the quiet tail starts.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8)) @(posedge clock);
      end
   end

   // CRC of a whole 16-bit word under the polynomial currently programmed;
   // used only to build the CRC bytes of frames.
   function automatic logic [7:0] word_crc8(input logic [15:0] w);
      logic [7:0] acc;
      acc = CRC_INIT ^ w[15:8];
      for (int i = 0; i < 16; i++) begin
         if (i == 8) begin
            acc = acc ^ w[7:0];
         end
         acc = acc[7] ? ({acc[6:0], 1'b0} ^ crc_poly_now) : {acc[6:0], 1'b0};
      end
      return acc;
   endfunction

   // Raw word with extra weight on the scale ends (-45/130 deg, 0/100 %).
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One beat on the byte port. Valid stays up between back-to-back beats;
   // a gap drops it right at the accepting edge.
   task automatic send_byte(input logic [7:0] b, input logic s);
      req_valid       <= 1'b1;
      req_frame_byte  <= b;
      req_frame_start <= s;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
      byte_slot = s ? 1 : ((byte_slot == 5) ? 0 : byte_slot + 1);
      if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Full frame; bad_t / bad_h flip bits of the matching CRC byte.
   task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input logic s, input logic bad_t, input logic bad_h);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = word_crc8(t_word) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
      h_crc = word_crc8(h_word) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
      send_byte(t_word[15:8], s);
      send_byte(t_word[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h_word[15:8], 1'b0);
      send_byte(h_word[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
   endtask

   // Hold the byte port until every predicted result has been taken, then let
   // the pipeline go quiet. The first edge lets the checker's count catch up
   // with the last accepted beat.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_crc_poly(input logic [7:0] p);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= p;
      crc_poly_now = p;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   initial begin
      logic [7:0] poly_plan [PHASES];
      int         phase_end;
      int         noise_len;
      logic       s;

      req_valid       <= 1'b0;
      req_frame_byte  <= 8'h00;
      req_frame_start <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 8'h00;
      reset           <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default, both extremes, a common alternative, then anything
      poly_plan = '{8'h31, 8'h00, 8'hFF, 8'h07, 8'($urandom_range(1, 254))};

      for (int phase = 0; phase < PHASES; phase++) begin
         // register writes only with the block idle; this is also the
         // sender pausing until all results are in
         wait_results_drained();
         write_crc_poly(poly_plan[phase]);

         if (phase == 0) begin
            // CRC error before any good frame: expect 0 deg / 0 %, no start flag
            send_frame(16'hFFFF, 16'h1234, 1'b0, 1'b1, 1'b0);
            // top of both scales: 130 deg, 100 %
            send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
            // partial frame dropped by a new start, then bottom of both scales
            send_byte(8'hA5, 1'b1);
            send_byte(8'h5A, 1'b0);
            send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
            // wrap without start flag; humidity CRC bad, so -45 / 0 repeat
            send_frame(16'd16000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
         end

         phase_end = (phase + 1) * TOTAL_BYTES / PHASES;
         while (sent_bytes < phase_end) begin
            if (phase == PHASES - 1 && sent_bytes >= TOTAL_BYTES - QUIET_BYTES) begin
               quiet_tail = 1'b1;
            end
            // some frames go back to back, the rest see sender gaps
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 3;
            if ($urandom_range(0, 9) < 8) begin
               // well-formed frame; when aligned, sometimes rely on the wrap
               s = (byte_slot != 0) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
               send_frame(pick_word(), pick_word(), s,
                          1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 7) == 0));
            end else begin
               // stray bytes with the odd restart mixed in
               noise_len = $urandom_range(1, 5);
               repeat (noise_len) begin
                  send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
               end
            end
         end
      end

      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : humidity_temperature_frame_decode_core_tb
`default_nettype wire

// ===== files.f =====
rtl/htfd_pkg.sv
rtl/humidity_temperature_frame_decode_core.sv
sim/humidity_temperature_frame_decode_checker.sv
sim/humidity_temperature_frame_decode_core_tb.sv
